/* hw/rtl/chm_pkg.sv */
// ----------------------------------------------------------------------------
// chm_pkg
// Shared types and constants of the chained hash map.
// ----------------------------------------------------------------------------
package chm_pkg;

	localparam int NUM_BUCKETS_DEF = 1024;
	localparam int WAYS_DEF        = 4;
	localparam int KEY_BYTES_DEF   = 8;

	localparam int KEY_W  = 64;
	localparam int VAL_W  = 64;
	localparam int SUM_W  = 11;
	localparam int RECIP_SHIFT = 26;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_LOOKUP = 2'd1,
		MODE_REMOVE = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef struct packed {
		logic [1:0]       mode;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} item_t;

	typedef enum logic [1:0] {
		ST_CLEAR = 2'd0,
		ST_IDLE  = 2'd1,
		ST_EXEC  = 2'd2
	} back_state_t;

endpackage

/* hw/rtl/chm_front.sv */
// ----------------------------------------------------------------------------
// chm_front
// Takes request beats, masks the key and works out its bucket in two stages.
// ----------------------------------------------------------------------------
module chm_front #(
	parameter int NUM_BUCKETS = chm_pkg::NUM_BUCKETS_DEF,
	parameter int KEY_BYTES   = chm_pkg::KEY_BYTES_DEF,
	parameter int BW          = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 mode,
	input  logic [chm_pkg::KEY_W-1:0]  key,
	input  logic [chm_pkg::VAL_W-1:0]  value,
	output logic                       push,
	input  logic                       fifo_full,
	output chm_pkg::item_t             push_item,
	output logic [BW-1:0]              push_bucket
);

	localparam int RW = chm_pkg::RECIP_SHIFT + 1;
	localparam logic [RW-1:0] RECIP =
		RW'(((64'd1 << chm_pkg::RECIP_SHIFT) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS));
	localparam logic [14:0] NB = 15'(NUM_BUCKETS);

	logic                       en;
	logic [chm_pkg::KEY_W-1:0]  kmask;
	logic [chm_pkg::SUM_W-1:0]  sum;
	logic                       v_s1, v_s2;
	chm_pkg::item_t             item_s1, item_s2;
	logic [chm_pkg::SUM_W-1:0]  sum_s1, sum_s2, q_s2;
	logic [RW+chm_pkg::SUM_W-1:0] prod;
	logic [chm_pkg::SUM_W+14:0] qn;
	logic [chm_pkg::SUM_W-1:0]  rem;

	always_comb begin
		kmask = '0;
		sum   = '0;
		for (int i = 0; i < 8; i++) begin
			if (i < KEY_BYTES) begin
				kmask[8*i +: 8] = 8'hFF;
				sum = sum + chm_pkg::SUM_W'(key[8*i +: 8]);
			end
		end
	end

	assign en       = !(v_s2 && fifo_full);
	assign in_stall = !en;
	assign prod     = (RW+chm_pkg::SUM_W)'(sum_s1) * (RW+chm_pkg::SUM_W)'(RECIP);
	assign qn       = (chm_pkg::SUM_W+15)'(q_s2) * (chm_pkg::SUM_W+15)'(NB);
	assign rem      = sum_s2 - qn[chm_pkg::SUM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= '{mode: mode, key: key & kmask, value: value};
			sum_s1  <= sum;
			item_s2 <= item_s1;
			sum_s2  <= sum_s1;
			q_s2    <= prod[chm_pkg::RECIP_SHIFT +: chm_pkg::SUM_W];
		end
	end

	assign push        = v_s2 && !fifo_full;
	assign push_item   = item_s2;
	assign push_bucket = BW'(rem);

endmodule

/* hw/rtl/chm_fifo.sv */
// ----------------------------------------------------------------------------
// chm_fifo
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module chm_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	logic [W-1:0] mem_q [2];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop)  rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

endmodule

/* hw/rtl/chm_back.sv */
// ----------------------------------------------------------------------------
// chm_back
// Bucket memories, the clearing sweep and the read-modify-write of a request.
// ----------------------------------------------------------------------------
module chm_back #(
	parameter int NUM_BUCKETS = chm_pkg::NUM_BUCKETS_DEF,
	parameter int WAYS        = chm_pkg::WAYS_DEF,
	parameter int BW          = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       fifo_empty,
	output logic                       pop,
	input  chm_pkg::item_t             head_item,
	input  logic [BW-1:0]              head_bucket,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       found,
	output logic [chm_pkg::VAL_W-1:0]  value_out,
	output logic                       status
);

	typedef logic [WAYS-1:0][chm_pkg::KEY_W-1:0] krow_t;
	typedef logic [WAYS-1:0][chm_pkg::VAL_W-1:0] vrow_t;

	krow_t             kmem [NUM_BUCKETS];
	vrow_t             vmem [NUM_BUCKETS];
	logic [WAYS-1:0]   bmem [NUM_BUCKETS];

	chm_pkg::back_state_t state_q, state_d;
	logic [BW-1:0]     clr_q;
	chm_pkg::item_t    item_q;
	logic [BW-1:0]     bkt_q;
	krow_t             krd_q, kwr;
	vrow_t             vrd_q, vwr;
	logic [WAYS-1:0]   brd_q, bwr;
	logic              kwe, vwe, bwe, done, hit, free;
	logic [WAYS-1:0]   hit_oh, free_oh;
	logic              out_valid_q, found_q, status_q;
	logic [chm_pkg::VAL_W-1:0] value_q, hit_val;
	logic              res_found, res_status;
	logic [chm_pkg::VAL_W-1:0] res_val;
	logic [BW-1:0]     waddr;

	always_comb begin
		hit_oh  = '0;
		free_oh = '0;
		hit     = 1'b0;
		free    = 1'b0;
		hit_val = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (brd_q[w] && krd_q[w] == item_q.key && !hit) begin
				hit       = 1'b1;
				hit_oh[w] = 1'b1;
				hit_val   = vrd_q[w];
			end
			if (!brd_q[w] && !free) begin
				free       = 1'b1;
				free_oh[w] = 1'b1;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		pop        = 1'b0;
		done       = 1'b0;
		kwe        = 1'b0;
		vwe        = 1'b0;
		bwe        = 1'b0;
		kwr        = krd_q;
		vwr        = vrd_q;
		bwr        = brd_q;
		waddr      = bkt_q;
		res_found  = 1'b0;
		res_status = 1'b0;
		res_val    = '0;
		case (state_q)
			chm_pkg::ST_CLEAR: begin
				bwe   = 1'b1;
				bwr   = '0;
				waddr = clr_q;
				if (clr_q == BW'(NUM_BUCKETS - 1)) state_d = chm_pkg::ST_IDLE;
			end
			chm_pkg::ST_IDLE: begin
				if (!fifo_empty) begin
					pop     = 1'b1;
					state_d = chm_pkg::ST_EXEC;
				end
			end
			chm_pkg::ST_EXEC: begin
				if (!out_valid_q || !out_stall) begin
					done    = 1'b1;
					state_d = chm_pkg::ST_IDLE;
					case (item_q.mode)
						chm_pkg::MODE_INSERT: begin
							for (int w = 0; w < WAYS; w++) begin
								if (hit_oh[w]) vwr[w] = item_q.value;
								if (!hit && free_oh[w]) begin
									vwr[w] = item_q.value;
									kwr[w] = item_q.key;
									bwr[w] = 1'b1;
								end
							end
							vwe        = hit || free;
							kwe        = !hit && free;
							bwe        = !hit && free;
							res_found  = hit;
							res_status = !hit && !free;
						end
						chm_pkg::MODE_LOOKUP: begin
							res_found = hit;
							res_val   = hit_val;
						end
						chm_pkg::MODE_REMOVE: begin
							bwr       = brd_q & ~hit_oh;
							bwe       = hit;
							res_found = hit;
						end
						default: ;
					endcase
				end
			end
			default: state_d = chm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= chm_pkg::ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == chm_pkg::ST_CLEAR) clr_q <= clr_q + BW'(1);
			if (done) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= head_item;
			bkt_q  <= head_bucket;
			krd_q  <= kmem[head_bucket];
			vrd_q  <= vmem[head_bucket];
			brd_q  <= bmem[head_bucket];
		end
		if (kwe) kmem[waddr] <= kwr;
		if (vwe) vmem[waddr] <= vwr;
		if (bwe) bmem[waddr] <= bwr;
		if (done) begin
			found_q  <= res_found;
			value_q  <= res_val;
			status_q <= res_status;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign value_out = value_q;
	assign status    = status_q;

	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == chm_pkg::ST_CLEAR |-> !pop)
		else $error("Request taken during the clearing sweep.");
	a_full_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(status && found))
		else $error("Full status reported together with a hit.");
	a_value_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && value_out != '0 |-> found)
		else $error("Value returned without a hit.");
	a_pop_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q == chm_pkg::ST_EXEC)
		else $error("Popped beat not executed.");

endmodule

/* hw/rtl/chained_hash_map_top.sv */
// ----------------------------------------------------------------------------
// chained_hash_map_top
// Key/value map with bucketed ways, insert, lookup and remove requests.
// ----------------------------------------------------------------------------
// After reset the block sweeps the valid memory one bucket per cycle until every
// bucket is cleared. Request beats are still taken during the sweep until the
// two front stages and the two-entry queue are full, but none is carried out
// before the sweep ends. The back part takes one request at a time: it reads
// the bucket row from the memories, then compares, writes back and registers
// the result once the output is free; the front part hashes in two stages and
// a two-entry queue keeps it running ahead.
module chained_hash_map_top #(
	parameter int NUM_BUCKETS = chm_pkg::NUM_BUCKETS_DEF,
	parameter int WAYS        = chm_pkg::WAYS_DEF,
	parameter int KEY_BYTES   = chm_pkg::KEY_BYTES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 mode,
	input  logic [chm_pkg::KEY_W-1:0]  key,
	input  logic [chm_pkg::VAL_W-1:0]  value,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       found,
	output logic [chm_pkg::VAL_W-1:0]  value_out,
	output logic                       status
);

	localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int IW = $bits(chm_pkg::item_t);

	logic            push, full, pop, empty;
	chm_pkg::item_t  push_item, head_item;
	logic [BW-1:0]   push_bucket, head_bucket;
	logic [IW+BW-1:0] head_flat;

	chm_front #(.NUM_BUCKETS(NUM_BUCKETS), .KEY_BYTES(KEY_BYTES), .BW(BW)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .key(key), .value(value), .push(push), .fifo_full(full),
		.push_item(push_item), .push_bucket(push_bucket)
	);

	chm_fifo #(.W(IW + BW)) u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata({push_item, push_bucket}),
		.full(full), .pop(pop), .rdata(head_flat), .empty(empty)
	);

	assign head_item   = chm_pkg::item_t'(head_flat[IW+BW-1:BW]);
	assign head_bucket = head_flat[BW-1:0];

	chm_back #(.NUM_BUCKETS(NUM_BUCKETS), .WAYS(WAYS), .BW(BW)) u_back (
		.clk(clk), .arst_n(arst_n), .fifo_empty(empty), .pop(pop),
		.head_item(head_item), .head_bucket(head_bucket),
		.out_valid(out_valid), .out_stall(out_stall), .found(found),
		.value_out(value_out), .status(status)
	);

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the chained hash map. A local copy of the table
// predicts every result; directed beats cover the mode and key extremes and
// full buckets, then random traffic on a small key pool with random stalls.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int NB = chm_pkg::NUM_BUCKETS_DEF;
	localparam int NW = chm_pkg::WAYS_DEF;
	localparam int SLOTS = NB * NW;
	localparam int WD_LIMIT = 20000;

	typedef struct packed {
		logic       found;
		logic [63:0] value_out;
		logic       status;
	} map_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] mode = chm_pkg::MODE_INSERT;
	logic [63:0] key = '0;
	logic [63:0] value = '0;
	logic out_valid;
	logic out_stall = 1'b1;
	logic found;
	logic [63:0] value_out;
	logic status;

	logic [63:0] tbl_key [SLOTS];
	logic [63:0] tbl_val [SLOTS];
	logic        tbl_used [SLOTS];

	chm_pkg::item_t pending_items [$];
	map_result_t expected_results [$];
	logic [63:0] key_pool [$];
	int errors = 0;
	int hold_cycles = 0;
	int send_gap = 0;
	int rx_count = 0;
	int idle_count = 0;
	bit sender_pause = 1'b0;

	chained_hash_map_top i_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .key(key), .value(value), .out_valid(out_valid),
		.out_stall(out_stall), .found(found), .value_out(value_out), .status(status)
	);

	always #2 clk = ~clk;

	function automatic int bucket_index(logic [63:0] k);
		int sum;
		sum = 0;
		for (int i = 0; i < 8; i++) begin
			sum += k[8*i +: 8];
		end
		return sum % NB;
	endfunction

	function automatic map_result_t predict_map(chm_pkg::item_t it);
		map_result_t r;
		int base, hit, free_way;
		r = '0;
		base = bucket_index(it.key) * NW;
		hit = -1;
		free_way = -1;
		for (int w = 0; w < NW; w++) begin
			if (tbl_used[base+w]) begin
				if (hit < 0 && tbl_key[base+w] == it.key) hit = w;
			end else if (free_way < 0) begin
				free_way = w;
			end
		end
		case (chm_pkg::mode_t'(it.mode))
			chm_pkg::MODE_INSERT: begin
				if (hit >= 0) begin
					tbl_val[base+hit] = it.value;
					r.found = 1'b1;
				end else if (free_way >= 0) begin
					tbl_key[base+free_way] = it.key;
					tbl_val[base+free_way] = it.value;
					tbl_used[base+free_way] = 1'b1;
				end else begin
					r.status = 1'b1;
				end
			end
			chm_pkg::MODE_LOOKUP: begin
				if (hit >= 0) begin
					r.found = 1'b1;
					r.value_out = tbl_val[base+hit];
				end
			end
			chm_pkg::MODE_REMOVE: begin
				if (hit >= 0) begin
					tbl_used[base+hit] = 1'b0;
					r.found = 1'b1;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic void push_item(logic [1:0] m, logic [63:0] k, logic [63:0] v);
		chm_pkg::item_t it;
		it.mode = m;
		it.key = k;
		it.value = v;
		pending_items = {pending_items, it};
	endfunction

	// Driver: a payload stays put until it is taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_results = {expected_results, predict_map('{mode, key, value})};
			end
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					in_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (!sender_pause && pending_items.size() > 0) begin
					in_valid <= 1'b1;
					{mode, key, value} <= pending_items.pop_front();
					send_gap <= $urandom_range(0, 10) * ($urandom_range(0, 3) == 0);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor and receiver stall.
	always @(posedge clk) begin
		map_result_t exp_r;
		int gap;
		if (arst_n) begin
			gap = 0;
			if (out_valid && !out_stall) begin
				if (rx_count == 400) gap = 200;
				else gap = $urandom_range(0, 10) * ($urandom_range(0, 2) == 0);
				rx_count++;
				if (expected_results.size() == 0) begin
					$display("%0t: result without expectation: found=%0b value=%h status=%0b",
						$time, found, value_out, status);
					errors++;
				end else begin
					exp_r = expected_results.pop_front();
					if (found !== exp_r.found) begin
						$display("%0t: found expected %0b actual %0b", $time, exp_r.found, found);
						errors++;
					end
					if (value_out !== exp_r.value_out) begin
						$display("%0t: value_out expected %h actual %h", $time,
							exp_r.value_out, value_out);
						errors++;
					end
					if (status !== exp_r.status) begin
						$display("%0t: status expected %0b actual %0b", $time, exp_r.status, status);
						errors++;
					end
				end
			end
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				out_stall <= 1'b1;
			end else if (gap > 0) begin
				hold_cycles <= gap - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog on cycles with no accepted beat.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_count <= 0;
		end else if (idle_count >= WD_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			idle_count <= idle_count + 1;
		end
	end

	initial begin
		logic [63:0] k, a, b;
		int m;
		for (int i = 0; i < SLOTS; i++) begin
			tbl_used[i] = 1'b0;
			tbl_key[i] = '0;
			tbl_val[i] = '0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		push_item(chm_pkg::MODE_LOOKUP, 64'd0, 64'd0);
		push_item(chm_pkg::MODE_REMOVE, 64'd0, '1);
		push_item(chm_pkg::MODE_INSERT, 64'd0, '1);
		push_item(chm_pkg::MODE_INSERT, '1, 64'd0);
		push_item(chm_pkg::MODE_LOOKUP, '1, '1);
		push_item(chm_pkg::MODE_INSERT, 64'd0, 64'h5555_aaaa_5555_aaaa);
		push_item(chm_pkg::MODE_LOOKUP, 64'd0, 64'd0);
		push_item(chm_pkg::MODE_NONE, 64'd0, '1);
		push_item(chm_pkg::MODE_LOOKUP, 64'd0, 64'd0);
		// Five keys with byte sum 3 share a bucket: the fifth insert finds it full.
		push_item(chm_pkg::MODE_INSERT, 64'h03, 64'd1);
		push_item(chm_pkg::MODE_INSERT, 64'h0102, 64'd2);
		push_item(chm_pkg::MODE_INSERT, 64'h0201, 64'd3);
		push_item(chm_pkg::MODE_INSERT, 64'h010101, 64'd4);
		push_item(chm_pkg::MODE_INSERT, 64'h0300, 64'd5);
		push_item(chm_pkg::MODE_INSERT, 64'h0102, 64'd6);
		push_item(chm_pkg::MODE_REMOVE, 64'h0201, 64'd0);
		push_item(chm_pkg::MODE_REMOVE, 64'h0201, 64'd0);
		push_item(chm_pkg::MODE_INSERT, 64'h0300, 64'd7);
		push_item(chm_pkg::MODE_LOOKUP, 64'h0300, 64'd0);
		push_item(chm_pkg::MODE_LOOKUP, 64'h0102, 64'd0);
		push_item(chm_pkg::MODE_NONE, '1, '1);
		// A key with its top byte set lands in the same bucket without matching.
		push_item(chm_pkg::MODE_LOOKUP, 64'h0100_0000_0000_0002, 64'd0);

		for (int i = 0; i < 48; i++) begin
			key_pool = {key_pool, rand64()};
		end
		for (int i = 0; i < 16; i++) begin
			a = 64'($urandom_range(0, 255));
			key_pool = {key_pool, a << (8 * (i % 8)) | (64'h80 << 56)};
		end
		for (int i = 0; i < 1250; i++) begin
			if (i == 800) begin
				while (pending_items.size() > 0 || in_valid) @(posedge clk);
				sender_pause = 1'b1;
				while (expected_results.size() > 0) @(posedge clk);
				sender_pause = 1'b0;
			end
			m = $urandom_range(0, 99);
			k = key_pool[$urandom_range(0, key_pool.size() - 1)];
			b = rand64();
			if ($urandom_range(0, 19) == 0) k = rand64();
			if (m < 40) push_item(chm_pkg::MODE_INSERT, k, b);
			else if (m < 72) push_item(chm_pkg::MODE_LOOKUP, k, b);
			else if (m < 96) push_item(chm_pkg::MODE_REMOVE, k, b);
			else push_item(chm_pkg::MODE_NONE, k, b);
			if (pending_items.size() > 40) begin
				while (pending_items.size() > 8) @(posedge clk);
			end
		end
		while (pending_items.size() > 0 || in_valid) @(posedge clk);
		while (expected_results.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/chm_pkg.sv
hw/rtl/chm_front.sv
hw/rtl/chm_fifo.sv
hw/rtl/chm_back.sv
hw/rtl/chained_hash_map_top.sv
test/tb_top.sv
